// File: src/tcc_pkg.sv
package tcc_pkg;

	localparam int RING_DEPTH = 120;
	localparam int MAX_PERIOD = RING_DEPTH / 3;
	localparam int RIDX_W = $clog2(RING_DEPTH);
	localparam int RCNT_W = $clog2(RING_DEPTH + 1);
	localparam int PIDX_W = $clog2(MAX_PERIOD);
	localparam int PLEN_W = $clog2(MAX_PERIOD + 1);
	localparam int DIFF_W = 32;
	localparam int SUM_W = DIFF_W + RCNT_W;
	localparam int DIV_RAW = SUM_W + PLEN_W + 2;
	localparam int DIV_W = (DIV_RAW > 41) ? DIV_RAW : 41;
	localparam int CORR_W = 40;
	localparam int PTS_W = 40;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REL_TOL = 1'd1;
	localparam logic [15:0] ZERO_THR_RST = 16'd3;
	localparam logic [13:0] REL_TOL_RST = 14'd100;
	localparam logic [13:0] TOL_SCALE = 14'd10000;

	typedef struct packed {
		logic              op;
		logic [PTS_W-1:0]  pts;
	} in_item_t;

	typedef struct packed {
		logic signed [CORR_W-1:0] correction;
		logic                     pattern_found;
		logic [5:0]               pattern_size;
	} out_item_t;

	typedef enum logic [5:0] {
		CMD_NOP, CMD_LATCH, CMD_FLUSH, CMD_FIRST, CMD_DIFF,
		CMD_C_INIT, CMD_C_RD, CMD_C_LD, CMD_C_NEW, CMD_C_REP, CMD_C_CMP,
		CMD_C_HIT, CMD_C_MISS, CMD_C_NEXT,
		CMD_P_INIT, CMD_P_READ, CMD_P_STEP, CMD_P_NEXTP, CMD_P_FOUND, CMD_P_NONE,
		CMD_A_START, CMD_A_READ, CMD_A_ACC, CMD_A_END, CMD_DIV_GO, CMD_A_STORE,
		CMD_K_ONE_RD, CMD_K_PHASE, CMD_K_READ, CMD_K_CMP, CMD_K_KEEP,
		CMD_R_INIT, CMD_R_READ, CMD_R_WRITE, CMD_R_DONE,
		CMD_S_INIT, CMD_S_READ, CMD_S_ACC, CMD_S_MUL, CMD_S_END, CMD_S_STORE,
		CMD_EMIT
	} cmd_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_DECODE, ST_DIFF,
		ST_C_INIT, ST_C_RD, ST_C_LD, ST_C_J, ST_C_CMP1, ST_C_CMP2, ST_C_NEXT,
		ST_P_INIT, ST_P_RD, ST_P_CMP,
		ST_A_START, ST_A_RD, ST_A_ACC, ST_A_DIV, ST_A_WAIT,
		ST_K_INIT, ST_K_ONE, ST_K_PH, ST_K_RD, ST_K_C1, ST_K_C2,
		ST_R_INIT, ST_R_RD, ST_R_WR, ST_R_DONE,
		ST_S_INIT, ST_S_RD, ST_S_ACC, ST_S_MUL, ST_S_SUB, ST_S_DIV, ST_S_WAIT,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic is_flush;
		logic first;
		logic ring_full;
		logic j_end;
		logic hit;
		logic i_last;
		logic p_done;
		logic cls_eq;
		logic p_last;
		logic base_end;
		logic div_busy;
		logic a_last;
		logic k_skip;
		logic n_one;
		logic one_small;
		logic k_last;
		logic r_end;
		logic s_end;
		logic out_free;
	} stat_t;

endpackage

// File: src/tcc_close.sv
module tcc_close
	import tcc_pkg::*;
(
	input  logic                     clk,
	input  logic signed [DIFF_W-1:0] a,
	input  logic signed [DIFF_W-1:0] b,
	input  logic [15:0]              zt,
	input  logic [13:0]              rt,
	output logic                     hit
);

	logic [DIFF_W-1:0] ma, mb;
	logic signed [DIFF_W:0] dd;
	logic [DIFF_W:0] dm;
	logic [DIFF_W+14:0] pl_c;
	logic [DIFF_W+13:0] pr_c;
	logic small_s1, bz_s1;
	logic [DIFF_W+14:0] pl_s1;
	logic [DIFF_W+13:0] pr_s1;

	always_comb begin
		ma = a[DIFF_W-1] ? DIFF_W'(-a) : a;
		mb = b[DIFF_W-1] ? DIFF_W'(-b) : b;
		dd = {b[DIFF_W-1], b} - {a[DIFF_W-1], a};
		dm = dd[DIFF_W] ? (DIFF_W+1)'(-dd) : dd;
		pl_c = dm * TOL_SCALE;
		pr_c = mb * rt;
	end

	// products registered, compare next cycle
	always_ff @(posedge clk) begin
		small_s1 <= (ma < {16'd0, zt}) && (mb < {16'd0, zt});
		bz_s1 <= (b == '0);
		pl_s1 <= pl_c;
		pr_s1 <= pr_c;
	end

	assign hit = small_s1 || (!bz_s1 && (pl_s1 <= {1'b0, pr_s1}));

endmodule

// File: src/tcc_div.sv
module tcc_div
	import tcc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_W-1:0] num,
	input  logic [RCNT_W-1:0]       den,
	output logic                    busy,
	output logic signed [DIV_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic busy_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] mag_q;
	logic [RCNT_W-1:0] rem_q, den_q;
	logic [RCNT_W:0] shl;
	logic ge;
	logic [DIV_W-1:0] abs_num;

	always_comb begin
		abs_num = num[DIV_W-1] ? DIV_W'(-num) : num;
		shl = {rem_q, mag_q[DIV_W-1]};
		ge = shl >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit a cycle; round half away from zero
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DIV_W-1];
			mag_q <= abs_num + DIV_W'(den >> 1);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? RCNT_W'(shl - {1'b0, den_q}) : shl[RCNT_W-1:0];
			mag_q <= {mag_q[DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// File: src/tcc_dp.sv
module tcc_dp
	import tcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_item,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output out_item_t             out_item,
	input  cmd_t                  cmd,
	output stat_t                 stat
);

	localparam logic [RCNT_W:0] DEPTH_X = (RCNT_W+1)'(RING_DEPTH);

	in_item_t in_q;
	logic [15:0] zt_q;
	logic [13:0] rt_q;
	logic [PTS_W-1:0] last_q;
	logic lastv_q, locked_q, out_valid_q;
	logic [RIDX_W-1:0] head_q, rp_q;
	logic [RCNT_W-1:0] count_q, i_q, j_q, ntypes_q, reps_q, div_den_q;
	logic [PLEN_W-1:0] len_q, phase_q, p_q, n_q;
	logic [PIDX_W-1:0] qi_q;
	logic [RCNT_W:0] base_q;
	logic signed [CORR_W-1:0] corr_q;
	logic signed [SUM_W-1:0] sum_q, part_q;
	logic signed [DIFF_W-1:0] d_q;
	logic signed [DIV_W-1:0] mula_q, mulb_q, div_num_q;
	out_item_t out_q;

	logic signed [DIFF_W-1:0] ring_mem [RING_DEPTH];
	logic signed [DIFF_W-1:0] rep_mem [RING_DEPTH];
	logic [RIDX_W-1:0] cls_mem [RING_DEPTH];
	logic signed [DIFF_W-1:0] pat_mem [MAX_PERIOD];
	logic signed [DIFF_W-1:0] sav_mem [MAX_PERIOD];

	logic signed [DIFF_W-1:0] ring_rd, rep_rd, pat_rd, sav_rd;
	logic [RIDX_W-1:0] cls_rd0, cls_rd1;
	logic [RIDX_W-1:0] ring_ra;
	logic [PIDX_W-1:0] pat_ra, sav_wa;
	logic signed [DIFF_W-1:0] sav_wd, cl_a, cl_b;
	logic cl_hit, div_busy;
	logic signed [DIV_W-1:0] div_quot;

	logic [RIDX_W-1:0] head_nx;
	logic signed [PTS_W:0] delta;
	logic signed [DIFF_W-1:0] dsat;
	logic [RCNT_W:0] ipp, kpos, hx, apos, bpp;
	logic [PLEN_W-1:0] ph_nx;
	logic signed [SUM_W+PLEN_W:0] pa, pb;
	logic signed [CORR_W-1:0] corr_sat;

	always_comb begin
		head_nx = (head_q == RIDX_W'(RING_DEPTH - 1)) ? '0 : head_q + RIDX_W'(1);
		delta = $signed({1'b0, in_q.pts}) - $signed({1'b0, last_q});
		if (delta > $signed((PTS_W+1)'(24'h7fffff)))
			dsat = 32'sh7fffffff;
		else if (delta < -$signed((PTS_W+1)'(24'h800000)))
			dsat = 32'sh80000000;
		else
			dsat = {delta[23:0], 8'h00};
		ipp = {1'b0, i_q} + (RCNT_W+1)'(p_q);
		kpos = base_q + {1'b0, i_q};
		hx = (RCNT_W+1)'(head_q);
		apos = (hx >= kpos) ? hx - kpos : hx + DEPTH_X - kpos;
		bpp = base_q + (RCNT_W+1)'(p_q);
		ring_ra = (cmd == CMD_A_READ) ? apos[RIDX_W-1:0] : rp_q;
		case (cmd)
			CMD_K_READ: pat_ra = qi_q;
			CMD_R_READ: pat_ra = i_q[PIDX_W-1:0];
			default:    pat_ra = '0;
		endcase
		sav_wa = i_q[PIDX_W-1:0];
		sav_wd = (cmd == CMD_K_KEEP) ? d_q : pat_rd;
		cl_a = (cmd == CMD_K_CMP) ? pat_rd : d_q;
		cl_b = (cmd == CMD_K_CMP) ? sav_rd : rep_rd;
		ph_nx = (phase_q + PLEN_W'(1) == len_q) ? '0 : phase_q + PLEN_W'(1);
		pa = sum_q * $signed({1'b0, phase_q});
		pb = part_q * $signed({1'b0, len_q});
		if (div_quot > $signed(DIV_W'(40'sh7fffffffff)))
			corr_sat = 40'sh7fffffffff;
		else if (div_quot < $signed(DIV_W'(40'sh8000000000)))
			corr_sat = 40'sh8000000000;
		else
			corr_sat = div_quot[CORR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_DIFF)
			ring_mem[head_nx] <= dsat;
		if (cmd == CMD_C_NEW)
			rep_mem[ntypes_q[RIDX_W-1:0]] <= d_q;
		if (cmd == CMD_C_NEW)
			cls_mem[i_q[RIDX_W-1:0]] <= ntypes_q[RIDX_W-1:0];
		else if (cmd == CMD_C_HIT)
			cls_mem[i_q[RIDX_W-1:0]] <= j_q[RIDX_W-1:0];
		if (cmd == CMD_A_STORE)
			pat_mem[i_q[PIDX_W-1:0]] <= div_quot[DIFF_W-1:0];
		if (cmd == CMD_K_KEEP || cmd == CMD_R_WRITE)
			sav_mem[sav_wa] <= sav_wd;
		ring_rd <= ring_mem[ring_ra];
		rep_rd <= rep_mem[j_q[RIDX_W-1:0]];
		cls_rd0 <= cls_mem[i_q[RIDX_W-1:0]];
		cls_rd1 <= cls_mem[ipp[RIDX_W-1:0]];
		pat_rd <= pat_mem[pat_ra];
		sav_rd <= sav_mem[i_q[PIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zt_q <= ZERO_THR_RST;
			rt_q <= REL_TOL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ZERO_THR: zt_q <= cfg_data;
				REG_REL_TOL:  rt_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			lastv_q <= 1'b0;
			head_q <= '0;
			count_q <= '0;
			len_q <= '0;
			phase_q <= '0;
			locked_q <= 1'b0;
			corr_q <= '0;
			out_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			ntypes_q <= '0;
			rp_q <= '0;
			p_q <= '0;
			n_q <= '0;
			qi_q <= '0;
			base_q <= '0;
			reps_q <= '0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			case (cmd)
				CMD_FLUSH: begin
					last_q <= '0;
					lastv_q <= 1'b0;
					head_q <= '0;
					count_q <= '0;
					len_q <= '0;
					phase_q <= '0;
					locked_q <= 1'b0;
					corr_q <= '0;
				end
				CMD_FIRST: begin
					last_q <= in_q.pts;
					lastv_q <= 1'b1;
				end
				CMD_DIFF: begin
					last_q <= in_q.pts;
					head_q <= head_nx;
					if (count_q < RCNT_W'(RING_DEPTH))
						count_q <= count_q + RCNT_W'(1);
				end
				CMD_C_INIT: begin
					i_q <= '0;
					ntypes_q <= '0;
					rp_q <= head_q;
				end
				CMD_C_LD: j_q <= '0;
				CMD_C_NEW: ntypes_q <= ntypes_q + RCNT_W'(1);
				CMD_C_MISS: j_q <= j_q + RCNT_W'(1);
				CMD_C_NEXT: begin
					i_q <= i_q + RCNT_W'(1);
					rp_q <= (rp_q == '0) ? RIDX_W'(RING_DEPTH - 1) : rp_q - RIDX_W'(1);
				end
				CMD_P_INIT: begin
					p_q <= PLEN_W'(1);
					i_q <= '0;
				end
				CMD_P_STEP: i_q <= i_q + RCNT_W'(1);
				CMD_P_NEXTP: begin
					p_q <= p_q + PLEN_W'(1);
					i_q <= '0;
				end
				CMD_P_FOUND: begin
					n_q <= p_q;
					i_q <= '0;
				end
				CMD_P_NONE: n_q <= '0;
				CMD_A_START: begin
					base_q <= '0;
					reps_q <= '0;
				end
				CMD_A_ACC: begin
					reps_q <= reps_q + RCNT_W'(1);
					base_q <= bpp;
				end
				CMD_A_STORE: i_q <= i_q + RCNT_W'(1);
				CMD_K_PHASE: begin
					phase_q <= ph_nx;
					qi_q <= PIDX_W'(ph_nx);
					i_q <= '0;
				end
				CMD_K_KEEP: begin
					i_q <= i_q + RCNT_W'(1);
					qi_q <= (PLEN_W'(qi_q) + PLEN_W'(1) == n_q) ? '0 : qi_q + PIDX_W'(1);
				end
				CMD_R_INIT: begin
					i_q <= '0;
					len_q <= n_q;
					phase_q <= '0;
				end
				CMD_R_WRITE: i_q <= i_q + RCNT_W'(1);
				CMD_R_DONE: begin
					corr_q <= '0;
					locked_q <= 1'b0;
				end
				CMD_S_INIT: begin
					i_q <= '0;
					locked_q <= 1'b1;
				end
				CMD_S_ACC: i_q <= i_q + RCNT_W'(1);
				CMD_S_STORE: corr_q <= corr_sat;
				CMD_EMIT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload and working values
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LATCH: in_q <= in_item;
			CMD_C_LD: d_q <= ring_rd;
			CMD_K_CMP: d_q <= pat_rd;
			CMD_A_START: sum_q <= '0;
			CMD_A_ACC: sum_q <= sum_q + SUM_W'(ring_rd);
			CMD_A_END: begin
				div_num_q <= DIV_W'(sum_q);
				div_den_q <= reps_q;
			end
			CMD_S_INIT: begin
				sum_q <= '0;
				part_q <= '0;
			end
			CMD_S_ACC: begin
				sum_q <= sum_q + SUM_W'(sav_rd);
				// tail of the saved pattern, the last phase entries
				if (i_q >= RCNT_W'(len_q - phase_q))
					part_q <= part_q + SUM_W'(sav_rd);
			end
			CMD_S_MUL: begin
				mula_q <= DIV_W'(pa);
				mulb_q <= DIV_W'(pb);
			end
			CMD_S_END: begin
				div_num_q <= mula_q - mulb_q;
				div_den_q <= RCNT_W'(len_q);
			end
			CMD_EMIT: begin
				out_q.correction <= corr_q;
				out_q.pattern_found <= locked_q;
				out_q.pattern_size <= locked_q ? 6'(len_q) : 6'd0;
			end
			default: ;
		endcase
	end

	tcc_close u_close (
		.clk (clk),
		.a   (cl_a),
		.b   (cl_b),
		.zt  (zt_q),
		.rt  (rt_q),
		.hit (cl_hit)
	);

	tcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd == CMD_DIV_GO),
		.num    (div_num_q),
		.den    (div_den_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_comb begin
		stat.is_flush = in_q.op;
		stat.first = !lastv_q;
		stat.ring_full = count_q >= RCNT_W'(RING_DEPTH - 1);
		stat.j_end = (j_q == ntypes_q);
		stat.hit = cl_hit;
		stat.i_last = (i_q == RCNT_W'(RING_DEPTH - 1));
		stat.p_done = (ipp >= DEPTH_X);
		stat.cls_eq = (cls_rd0 == cls_rd1);
		stat.p_last = (p_q == PLEN_W'(MAX_PERIOD));
		stat.base_end = (bpp > DEPTH_X);
		stat.div_busy = div_busy;
		stat.a_last = (i_q == RCNT_W'(p_q) - RCNT_W'(1));
		stat.k_skip = (n_q == '0) || (n_q != len_q);
		stat.n_one = (n_q == PLEN_W'(1));
		stat.one_small = $signed({pat_rd[DIFF_W-1], pat_rd}) <= $signed({17'd0, zt_q});
		stat.k_last = (i_q == RCNT_W'(len_q) - RCNT_W'(1));
		stat.r_end = (i_q == RCNT_W'(n_q));
		stat.s_end = (i_q == RCNT_W'(len_q));
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// File: src/tcc_ctrl.sv
module tcc_ctrl
	import tcc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	st_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd = CMD_NOP;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = CMD_LATCH;
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.is_flush) begin
					cmd = CMD_FLUSH;
					state_nx = ST_EMIT;
				end else if (stat.first) begin
					cmd = CMD_FIRST;
					state_nx = ST_EMIT;
				end else
					state_nx = ST_DIFF;
			end
			ST_DIFF: begin
				cmd = CMD_DIFF;
				state_nx = stat.ring_full ? ST_C_INIT : ST_EMIT;
			end
			ST_C_INIT: begin
				cmd = CMD_C_INIT;
				state_nx = ST_C_RD;
			end
			ST_C_RD: begin
				cmd = CMD_C_RD;
				state_nx = ST_C_LD;
			end
			ST_C_LD: begin
				cmd = CMD_C_LD;
				state_nx = ST_C_J;
			end
			ST_C_J: begin
				if (stat.j_end) begin
					cmd = CMD_C_NEW;
					state_nx = ST_C_NEXT;
				end else begin
					cmd = CMD_C_REP;
					state_nx = ST_C_CMP1;
				end
			end
			ST_C_CMP1: begin
				cmd = CMD_C_CMP;
				state_nx = ST_C_CMP2;
			end
			ST_C_CMP2: begin
				if (stat.hit) begin
					cmd = CMD_C_HIT;
					state_nx = ST_C_NEXT;
				end else begin
					cmd = CMD_C_MISS;
					state_nx = ST_C_J;
				end
			end
			ST_C_NEXT: begin
				cmd = CMD_C_NEXT;
				state_nx = stat.i_last ? ST_P_INIT : ST_C_RD;
			end
			ST_P_INIT: begin
				cmd = CMD_P_INIT;
				state_nx = ST_P_RD;
			end
			ST_P_RD: begin
				if (stat.p_done) begin
					cmd = CMD_P_FOUND;
					state_nx = ST_A_START;
				end else begin
					cmd = CMD_P_READ;
					state_nx = ST_P_CMP;
				end
			end
			ST_P_CMP: begin
				if (stat.cls_eq) begin
					cmd = CMD_P_STEP;
					state_nx = ST_P_RD;
				end else if (stat.p_last) begin
					cmd = CMD_P_NONE;
					state_nx = ST_K_INIT;
				end else begin
					cmd = CMD_P_NEXTP;
					state_nx = ST_P_RD;
				end
			end
			ST_A_START: begin
				cmd = CMD_A_START;
				state_nx = ST_A_RD;
			end
			ST_A_RD: begin
				if (stat.base_end) begin
					cmd = CMD_A_END;
					state_nx = ST_A_DIV;
				end else begin
					cmd = CMD_A_READ;
					state_nx = ST_A_ACC;
				end
			end
			ST_A_ACC: begin
				cmd = CMD_A_ACC;
				state_nx = ST_A_RD;
			end
			ST_A_DIV: begin
				cmd = CMD_DIV_GO;
				state_nx = ST_A_WAIT;
			end
			ST_A_WAIT: begin
				if (!stat.div_busy) begin
					cmd = CMD_A_STORE;
					state_nx = stat.a_last ? ST_K_INIT : ST_A_START;
				end
			end
			ST_K_INIT: begin
				if (stat.k_skip)
					state_nx = ST_R_INIT;
				else if (stat.n_one) begin
					cmd = CMD_K_ONE_RD;
					state_nx = ST_K_ONE;
				end else
					state_nx = ST_K_PH;
			end
			ST_K_ONE: state_nx = stat.one_small ? ST_R_INIT : ST_K_PH;
			ST_K_PH: begin
				cmd = CMD_K_PHASE;
				state_nx = ST_K_RD;
			end
			ST_K_RD: begin
				cmd = CMD_K_READ;
				state_nx = ST_K_C1;
			end
			ST_K_C1: begin
				cmd = CMD_K_CMP;
				state_nx = ST_K_C2;
			end
			ST_K_C2: begin
				if (stat.hit) begin
					cmd = CMD_K_KEEP;
					state_nx = stat.k_last ? ST_S_INIT : ST_K_RD;
				end else
					state_nx = ST_R_INIT;
			end
			ST_R_INIT: begin
				cmd = CMD_R_INIT;
				state_nx = ST_R_RD;
			end
			ST_R_RD: begin
				if (stat.r_end)
					state_nx = ST_R_DONE;
				else begin
					cmd = CMD_R_READ;
					state_nx = ST_R_WR;
				end
			end
			ST_R_WR: begin
				cmd = CMD_R_WRITE;
				state_nx = ST_R_RD;
			end
			ST_R_DONE: begin
				cmd = CMD_R_DONE;
				state_nx = ST_EMIT;
			end
			ST_S_INIT: begin
				cmd = CMD_S_INIT;
				state_nx = ST_S_RD;
			end
			ST_S_RD: begin
				if (stat.s_end)
					state_nx = ST_S_MUL;
				else begin
					cmd = CMD_S_READ;
					state_nx = ST_S_ACC;
				end
			end
			ST_S_ACC: begin
				cmd = CMD_S_ACC;
				state_nx = ST_S_RD;
			end
			ST_S_MUL: begin
				cmd = CMD_S_MUL;
				state_nx = ST_S_SUB;
			end
			ST_S_SUB: begin
				cmd = CMD_S_END;
				state_nx = ST_S_DIV;
			end
			ST_S_DIV: begin
				cmd = CMD_DIV_GO;
				state_nx = ST_S_WAIT;
			end
			ST_S_WAIT: begin
				if (!stat.div_busy) begin
					cmd = CMD_S_STORE;
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd = CMD_EMIT;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// File: src/timestamp_cadence_correction.sv
// Timestamp cadence correction: one result beat per input beat, one item in
// flight at a time; the input is taken again while the last result waits in
// the output register. A flush, the first stamp and a stamp while the ring of
// N = 120 differences fills go straight to the result. Once the ring is full
// an item runs the whole search through one sequencer: classing, each compare
// through the shared tolerance unit; a class-sequence test per candidate
// period; averaging with one serial division per pattern entry; then the lock
// test and correction.
module timestamp_cadence_correction
	import tcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	stat_t stat;

	tcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: src/tcc_checker.sv
module tcc_checker
	import tcc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// a held result beat must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	// one item at a time: no second beat straight after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the cycle after a beat");

	a_unlocked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.pattern_found |->
			out_item.pattern_size == 6'd0 && out_item.correction == '0)
		else $error("unlocked result carries size or correction");

	a_locked_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.pattern_found |-> out_item.pattern_size != 6'd0)
		else $error("locked result with empty pattern");

endmodule

bind timestamp_cadence_correction tcc_checker u_chk (.*);

// File: verif/tb_timestamp_cadence_correction.sv
module tb_timestamp_cadence_correction;
	import tcc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;
	localparam int   STALL_LIMIT = 400000;
	localparam logic [PTS_W-1:0] PTS_MAX = {PTS_W{1'b1}};

	class cadence_scoreboard;
		int unsigned zero_thr;
		int unsigned rel_tol;
		longint      last_stamp;
		bit          stamp_seen;
		int          diff_ring[RING_DEPTH];
		int          head;
		int          fill;
		longint      saved[MAX_PERIOD+1];
		longint      pat[MAX_PERIOD+1];
		int          cls[RING_DEPTH];
		int          rep[RING_DEPTH];
		int          saved_len;
		int          phase;
		bit          locked;
		longint      corr;
		out_item_t   expected_q[$];
		int          errors;
		int          results;
		int          lock_beats;

		function new();
			zero_thr = ZERO_THR_RST;
			rel_tol = REL_TOL_RST;
			errors = 0;
			results = 0;
			lock_beats = 0;
			clear();
		endfunction

		function void clear();
			last_stamp = 0;
			stamp_seen = 0;
			head = 0;
			fill = 0;
			saved_len = 0;
			phase = 0;
			locked = 0;
			corr = 0;
			foreach (diff_ring[i]) diff_ring[i] = 0;
			foreach (saved[i]) saved[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_ZERO_THR)
				zero_thr = data;
			else
				rel_tol = data[13:0];
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function bit close_enough(longint a, longint b);
			if (mag(a) < longint'(zero_thr) && mag(b) < longint'(zero_thr))
				return 1;
			if (b == 0)
				return 0;
			return mag(b - a) * 10000 <= longint'(rel_tol) * mag(b);
		endfunction

		function longint div_round(longint num, longint den);
			if (num >= 0)
				return (num + den / 2) / den;
			return -((-num + den / 2) / den);
		endfunction

		function int past(int back);
			return diff_ring[(head + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH];
		endfunction

		// class sequence, newest first; shortest period wins
		function int find_period();
			int ntypes;
			bit hit;
			bit ok;
			int reps;
			longint acc;
			ntypes = 0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				hit = 0;
				for (int j = 0; j < ntypes && !hit; j++) begin
					if (close_enough(past(i), rep[j])) begin
						cls[i] = j;
						hit = 1;
					end
				end
				if (!hit) begin
					rep[ntypes] = past(i);
					cls[i] = ntypes;
					ntypes++;
				end
			end
			for (int p = 1; p <= MAX_PERIOD; p++) begin
				ok = 1;
				for (int i = 0; i + p < RING_DEPTH && ok; i++)
					if (cls[i] != cls[i+p]) ok = 0;
				if (ok) begin
					reps = RING_DEPTH / p;
					for (int i = 0; i < p; i++) begin
						acc = 0;
						for (int j = 0; j < reps; j++)
							acc += past(j * p + i);
						pat[i] = div_round(acc, reps);
					end
					return p;
				end
			end
			return 0;
		endfunction

		function bit lock_test(int n);
			longint d;
			bit ok;
			ok = !(n != saved_len || n < 1 || (n == 1 && pat[0] <= longint'(zero_thr)));
			if (ok) begin
				phase = (phase + 1) % saved_len;
				for (int i = 0; i < saved_len && ok; i++) begin
					d = pat[(phase + i) % n];
					if (!close_enough(d, saved[i]))
						ok = 0;
					else
						saved[i] = d;
				end
			end
			if (!ok) begin
				for (int i = 0; i < n; i++) saved[i] = pat[i];
				saved_len = n;
				phase = 0;
			end
			return ok;
		endfunction

		function void push_expected();
			out_item_t e;
			e.correction = corr[CORR_W-1:0];
			e.pattern_found = locked;
			e.pattern_size = locked ? saved_len[5:0] : 6'd0;
			expected_q.insert(expected_q.size(), e);
		endfunction

		function void note_input(in_item_t it);
			longint d;
			longint total;
			longint part;
			longint num;
			int n;
			if (it.op == OP_FLUSH) begin
				clear();
			end else if (!stamp_seen) begin
				last_stamp = it.pts;
				stamp_seen = 1;
			end else begin
				d = (longint'(it.pts) - last_stamp) * 256;
				if (d > 64'sd2147483647) d = 64'sd2147483647;
				if (d < -64'sd2147483648) d = -64'sd2147483648;
				head = (head + 1) % RING_DEPTH;
				diff_ring[head] = int'(d);
				last_stamp = it.pts;
				if (fill < RING_DEPTH) fill++;
				if (fill == RING_DEPTH) begin
					n = find_period();
					if (!lock_test(n)) begin
						corr = 0;
						locked = 0;
					end else begin
						locked = 1;
						total = 0;
						for (int i = 0; i < saved_len; i++) total += saved[i];
						part = 0;
						for (int i = 0; i < phase; i++) part += saved[saved_len - 1 - i];
						num = div_round(total * phase - part * saved_len, saved_len);
						if (num > 64'sd549755813887) num = 64'sd549755813887;
						if (num < -64'sd549755813888) num = -64'sd549755813888;
						corr = num;
					end
				end
			end
			push_expected();
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			results++;
			if (got.pattern_found) lock_beats++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: corr %0d found %0b size %0d",
						got.correction, got.pattern_found, got.pattern_size);
				return;
			end
			e = expected_q.pop_front();
			if (got.correction !== e.correction || got.pattern_found !== e.pattern_found ||
					got.pattern_size !== e.pattern_size) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: corr %0d/%0d found %0b/%0b size %0d/%0d (exp/got)",
						e.correction, got.correction, e.pattern_found, got.pattern_found,
						e.pattern_size, got.pattern_size);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cadence_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int stall_cycles = 0;
	int items_sent = 0;
	logic [PTS_W-1:0] cur_pts = '0;

	timestamp_cadence_correction dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side: check, random back-pressure, stall watchdog
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_item);
		if ((out_valid && out_ready) || (in_valid && in_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// leaves valid high on return; the next call or the caller lowers it
	task automatic send(logic op, logic [PTS_W-1:0] pts);
		in_item_t it;
		it.op = op;
		it.pts = pts;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic stamp_step(longint unsigned step_us);
		cur_pts = cur_pts + step_us[PTS_W-1:0];
		send(OP_ADD, cur_pts);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] zthr, logic [13:0] rtol);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ZERO_THR;
		cfg_data <= zthr;
		@(posedge clk);
		sb.set_reg(REG_ZERO_THR, zthr);
		cfg_index <= REG_REL_TOL;
		cfg_data <= CFG_DATA_W'(rtol);
		@(posedge clk);
		sb.set_reg(REG_REL_TOL, CFG_DATA_W'(rtol));
		cfg_wr_en <= 1'b0;
	endtask

	// repeating cadence of len steps (all zero if zero_steps) with small jitter and rare random steps
	task automatic cadence_run(int len, int count, bit zero_steps);
		int unsigned steps[MAX_PERIOD];
		int jitter;
		jitter = $urandom_range(0, 2);
		for (int k = 0; k < len; k++)
			steps[k] = zero_steps ? 0 : $urandom_range(1000, 60000);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 2)
				stamp_step($urandom_range(0, 100000));
			else
				stamp_step(steps[k % len] + $urandom_range(0, jitter));
		end
	endtask

	task automatic random_phase(int ph);
		int len;
		int tail;
		case (ph)
			0: len = $urandom_range(1, 3);
			1: len = ($urandom_range(1) != 0) ? MAX_PERIOD : 5;
			default: len = $urandom_range(2, 5);
		endcase
		tail = (len > 8) ? 4 : 18;
		send(OP_FLUSH, PTS_W'($urandom()));
		cur_pts = PTS_W'({$urandom(), $urandom()});
		cadence_run(len, RING_DEPTH + 1 + tail, 0);
		for (int k = 0; k < 3; k++) begin
			cur_pts = PTS_W'({$urandom(), $urandom()});
			send(OP_ADD, cur_pts);
		end
		cadence_run($urandom_range(1, 4), tail, 0);
		// flat run of zero steps plus small jitter: single zero entry must not lock
		send(OP_FLUSH, '0);
		cadence_run(1, RING_DEPTH + 4, 1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_regs(ZERO_THR_RST, REL_TOL_RST);

		// directed: extremes, saturation both ways, zero step, flushes
		send(OP_FLUSH, PTS_MAX);
		send(OP_ADD, '0);
		send(OP_ADD, PTS_MAX);
		send(OP_ADD, '0);
		send(OP_ADD, 40'd5);
		send(OP_ADD, 40'd5);
		send(OP_ADD, 40'h55_5555_5555);
		send(OP_ADD, 40'hAA_AAAA_AAAA);
		send(OP_FLUSH, '0);
		send(OP_ADD, PTS_MAX);
		send(OP_ADD, PTS_MAX - 40'd1);
		send(OP_FLUSH, 40'h12_3456_789A);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle = 21; recv_idle = 58; write_regs(16'd3, 14'd100); end
				1: begin send_idle = 58; recv_idle = 21; write_regs(16'd0, 14'd10000); end
				default: begin send_idle = 0; recv_idle = 0; write_regs(16'hFFFF, 14'd0); end
			endcase
			random_phase(ph);
			drain();
			if (ph == 2) begin
				write_regs(16'd500, 14'd50);
				random_phase(0);
				drain();
			end
		end

		repeat (200) @(posedge clk);
		$display("%0d input beats over three pacing phases and four register settings;",
			items_sent);
		$display("%0d result beats checked, %0d of them with cadence lock", sb.results,
			sb.lock_beats);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
src/tcc_pkg.sv
src/tcc_close.sv
src/tcc_div.sv
src/tcc_dp.sv
src/tcc_ctrl.sv
src/timestamp_cadence_correction.sv
src/tcc_checker.sv
verif/tb_timestamp_cadence_correction.sv
